// ----- rtl/assert_macros.svh -----
// Assertion macros for the max pooling RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/mp2d_pkg.sv -----
// Shared types and constants for the 2-D max pooling core.
package mp2d_pkg;

    // Parameter defaults
    localparam int DEF_MAX_WIDTH   = 256;
    localparam int DEF_MAX_WINDOW  = 8;
    localparam int DEF_SAMPLE_BITS = 16;

    // Fixed field widths
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int HEIGHT_W   = 9;
    localparam int WIDTH_W    = 9;
    localparam int WINDOW_W   = 4;
    localparam int STEP_W     = 4;
    localparam int CHANNELS_W = 11;
    localparam int ROW_W      = 8;
    localparam int CHAN_W     = 10;
    localparam int OUT_POS_W  = 8;

    // Register limits and reset values
    localparam int MAX_HEIGHT   = 256;
    localparam int MAX_CHANNELS = 1024;
    localparam logic [HEIGHT_W-1:0]   RST_MAP_HEIGHT    = 9'd8;
    localparam logic [WIDTH_W-1:0]    RST_MAP_WIDTH     = 9'd8;
    localparam logic [WINDOW_W-1:0]   RST_WINDOW_SIZE   = 4'd2;
    localparam logic [STEP_W-1:0]     RST_STEP_SIZE     = 4'd2;
    localparam logic [CHANNELS_W-1:0] RST_CHANNEL_COUNT = 11'd1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAP_HEIGHT    = 3'd0,
        CFG_MAP_WIDTH     = 3'd1,
        CFG_WINDOW_SIZE   = 3'd2,
        CFG_STEP_SIZE     = 3'd3,
        CFG_CHANNEL_COUNT = 3'd4
    } cfg_reg_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_EMIT
    } state_t;

    // Window tracker status for one dimension
    typedef struct packed {
        logic hit;
        logic last;
    } win_status_t;

endpackage

// ----- rtl/mp2d_line_store.sv -----
// Line store: simple dual-port synchronous RAM with a registered read.
module mp2d_line_store #(
    parameter int DEPTH  = mp2d_pkg::DEF_MAX_WINDOW * mp2d_pkg::DEF_MAX_WIDTH,
    parameter int DATA_W = mp2d_pkg::DEF_SAMPLE_BITS
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/mp2d_win_track.sv -----
// Pooling window tracker for one dimension: finds the window that ends at a position.
module mp2d_win_track #(
    parameter int POS_W = mp2d_pkg::ROW_W,
    parameter int WIN_W = $clog2(mp2d_pkg::DEF_MAX_WINDOW + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        clear,
    input  logic                        advance,
    input  logic [POS_W:0]              n_dim,
    input  logic [WIN_W-1:0]            win,
    input  logic [mp2d_pkg::STEP_W-1:0] step,
    input  logic [POS_W-1:0]            pos,
    output mp2d_pkg::win_status_t       status,
    output logic [POS_W-1:0]            idx,
    output logic [POS_W-1:0]            first_pos
);

    // Room for a start past the edge plus a full window
    localparam int TRK_W = POS_W + 3;

    logic [TRK_W-1:0] start_reg, start_next;
    logic [POS_W-1:0] idx_reg, idx_next;
    logic [TRK_W-1:0] end_pos;
    logic [TRK_W-1:0] n_last;
    logic [TRK_W-1:0] pos_x;

    // Unclipped end of the pending window and the last position of the map
    assign end_pos = start_reg + TRK_W'(win) - TRK_W'(1);
    assign n_last  = TRK_W'(n_dim) - TRK_W'(1);
    assign pos_x   = TRK_W'(pos);

    // Hit on the clipped end; last when no further window exists
    always_comb
    begin
        status.hit  = (start_reg <= pos_x) &&
                      ((pos_x == end_pos) || ((pos_x == n_last) && (end_pos > n_last)));
        status.last = (end_pos >= n_last) ||
                      ((start_reg + TRK_W'(step)) >= TRK_W'(n_dim));
    end

    assign idx       = idx_reg;
    assign first_pos = start_reg[POS_W-1:0];

    // Step to the next window origin
    always_comb
    begin
        start_next = start_reg;
        idx_next   = idx_reg;
        if (clear)
        begin
            start_next = '0;
            idx_next   = '0;
        end
        else if (advance)
        begin
            start_next = start_reg + TRK_W'(step);
            idx_next   = idx_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            start_reg <= start_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

// ----- rtl/max_pooling_2d_core.sv -----
// A beat that closes no window is taken in the idle state; one that closes an R x C clipped
// window starts a scan of its R*C stored samples, then passes the LAST and EMIT states,
// plus any wait for the output register. Throughput: set by the single read port of the
// line store, one stored sample per cycle; input stalls from a window hit until its result loads.
// Reset: asynchronous, active low; clears configuration registers to their defaults and positions to zero.
// The line store is not cleared; its entries are valid once written.
module max_pooling_2d_core #(
    parameter int MAX_WIDTH   = mp2d_pkg::DEF_MAX_WIDTH,
    parameter int MAX_WINDOW  = mp2d_pkg::DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS = mp2d_pkg::DEF_SAMPLE_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mp2d_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mp2d_pkg::CFG_DATA_W-1:0] cfg_data,
    // sample input
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic signed [SAMPLE_BITS-1:0]   sample,
    // pooled output
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [SAMPLE_BITS-1:0]   pooled_value,
    output logic [mp2d_pkg::CHAN_W-1:0]     channel_index,
    output logic [mp2d_pkg::OUT_POS_W-1:0]  out_row,
    output logic [mp2d_pkg::OUT_POS_W-1:0]  out_col,
    output logic                            layer_done
);

`include "assert_macros.svh"

    localparam int CW          = $clog2(MAX_WIDTH);
    localparam int WDIM_W      = CW + 1;
    localparam int WIN_W       = $clog2(MAX_WINDOW + 1);
    localparam int STORE_DEPTH = MAX_WINDOW * MAX_WIDTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int ROW_W       = mp2d_pkg::ROW_W;
    localparam int CHAN_W      = mp2d_pkg::CHAN_W;
    localparam logic [ADDR_W-1:0] LAST_BASE = ADDR_W'(STORE_DEPTH - MAX_WIDTH);
    localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(MAX_WIDTH);
    localparam logic signed [SAMPLE_BITS-1:0] MIN_VALUE = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // Configuration registers
    logic [mp2d_pkg::HEIGHT_W-1:0]   map_height_reg;
    logic [mp2d_pkg::WIDTH_W-1:0]    map_width_reg;
    logic [mp2d_pkg::WINDOW_W-1:0]   window_size_reg;
    logic [mp2d_pkg::STEP_W-1:0]     step_size_reg;
    logic [mp2d_pkg::CHANNELS_W-1:0] channel_count_reg;
    logic cfg_write;
    logic cfg_known;

    // Effective dimensions
    logic [mp2d_pkg::HEIGHT_W-1:0]   h_eff;
    logic [WDIM_W-1:0]               w_eff;
    logic [WIN_W-1:0]                k_eff;
    logic [mp2d_pkg::STEP_W-1:0]     s_eff;
    logic [mp2d_pkg::CHANNELS_W-1:0] c_eff;

    // Positions and line store write base
    logic [CW-1:0]     col_pos_reg, col_pos_next;
    logic [ROW_W-1:0]  row_pos_reg, row_pos_next;
    logic [CHAN_W-1:0] chan_pos_reg, chan_pos_next;
    logic [ADDR_W-1:0] wr_base_reg, wr_base_next;
    logic col_end, row_end, chan_end;
    logic accept;

    // Window trackers
    mp2d_pkg::win_status_t row_status, col_status;
    logic [ROW_W-1:0] row_idx, row_first;
    logic [CW-1:0]    col_idx, col_first;
    logic row_clear, row_adv, col_clear, col_adv;
    logic win_hit;

    // Scan and accumulate
    mp2d_pkg::state_t state_reg, state_next;
    logic [ADDR_W-1:0] scan_base_reg, scan_base_next;
    logic [CW-1:0]     scan_col_reg, scan_col_next;
    logic [CW-1:0]     scan_first_reg, scan_first_next;
    logic [CW-1:0]     scan_last_reg, scan_last_next;
    logic [WIN_W-1:0]  rows_left_reg, rows_left_next;
    logic scan_done;
    logic rd_en;
    logic rd_pend_reg;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic signed [SAMPLE_BITS-1:0] rd_data;
    logic signed [SAMPLE_BITS-1:0] best_reg, best_next;

    // Window metadata and output register
    logic [CHAN_W-1:0]              meta_chan_reg;
    logic [mp2d_pkg::OUT_POS_W-1:0] meta_row_reg, meta_col_reg;
    logic                           meta_done_reg;
    logic out_load;
    logic out_valid_reg;
    logic signed [SAMPLE_BITS-1:0]  pooled_reg;
    logic [CHAN_W-1:0]              chan_out_reg;
    logic [mp2d_pkg::OUT_POS_W-1:0] row_out_reg, col_out_reg;
    logic                           done_out_reg;

    // ---------------------------------------------------------------
    // Configuration port
    assign cfg_write = cfg_valid && cfg_ready;

    assign cfg_known = cfg_index inside {mp2d_pkg::CFG_MAP_HEIGHT,
                                         mp2d_pkg::CFG_MAP_WIDTH,
                                         mp2d_pkg::CFG_WINDOW_SIZE,
                                         mp2d_pkg::CFG_STEP_SIZE,
                                         mp2d_pkg::CFG_CHANNEL_COUNT};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_height_reg    <= mp2d_pkg::RST_MAP_HEIGHT;
            map_width_reg     <= mp2d_pkg::RST_MAP_WIDTH;
            window_size_reg   <= mp2d_pkg::RST_WINDOW_SIZE;
            step_size_reg     <= mp2d_pkg::RST_STEP_SIZE;
            channel_count_reg <= mp2d_pkg::RST_CHANNEL_COUNT;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                mp2d_pkg::CFG_MAP_HEIGHT:
                    map_height_reg <= cfg_data[mp2d_pkg::HEIGHT_W-1:0];
                mp2d_pkg::CFG_MAP_WIDTH:
                    map_width_reg <= cfg_data[mp2d_pkg::WIDTH_W-1:0];
                mp2d_pkg::CFG_WINDOW_SIZE:
                    window_size_reg <= cfg_data[mp2d_pkg::WINDOW_W-1:0];
                mp2d_pkg::CFG_STEP_SIZE:
                    step_size_reg <= cfg_data[mp2d_pkg::STEP_W-1:0];
                mp2d_pkg::CFG_CHANNEL_COUNT:
                    channel_count_reg <= cfg_data[mp2d_pkg::CHANNELS_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // Zero acts as one, oversized values saturate
    always_comb
    begin
        if (map_height_reg == '0)
            h_eff = mp2d_pkg::HEIGHT_W'(1);
        else if (32'(map_height_reg) > 32'(mp2d_pkg::MAX_HEIGHT))
            h_eff = mp2d_pkg::HEIGHT_W'(mp2d_pkg::MAX_HEIGHT);
        else
            h_eff = map_height_reg;

        if (map_width_reg == '0)
            w_eff = WDIM_W'(1);
        else if (32'(map_width_reg) > 32'(MAX_WIDTH))
            w_eff = WDIM_W'(MAX_WIDTH);
        else
            w_eff = WDIM_W'(map_width_reg);

        if (window_size_reg == '0)
            k_eff = WIN_W'(1);
        else if (32'(window_size_reg) > 32'(MAX_WINDOW))
            k_eff = WIN_W'(MAX_WINDOW);
        else
            k_eff = WIN_W'(window_size_reg);

        if (step_size_reg == '0)
            s_eff = mp2d_pkg::STEP_W'(1);
        else
            s_eff = step_size_reg;

        if (channel_count_reg == '0)
            c_eff = mp2d_pkg::CHANNELS_W'(1);
        else if (32'(channel_count_reg) > 32'(mp2d_pkg::MAX_CHANNELS))
            c_eff = mp2d_pkg::CHANNELS_W'(mp2d_pkg::MAX_CHANNELS);
        else
            c_eff = channel_count_reg;
    end

    // ---------------------------------------------------------------
    // Raster position counters
    assign accept   = in_valid && !in_stall;
    assign col_end  = (WDIM_W'(col_pos_reg) == (w_eff - WDIM_W'(1)));
    assign row_end  = ({1'b0, row_pos_reg} == (h_eff - mp2d_pkg::HEIGHT_W'(1)));
    assign chan_end = ({1'b0, chan_pos_reg} == (c_eff - mp2d_pkg::CHANNELS_W'(1)));

    always_comb
    begin
        col_pos_next  = col_pos_reg;
        row_pos_next  = row_pos_reg;
        chan_pos_next = chan_pos_reg;
        wr_base_next  = wr_base_reg;
        if (cfg_write && cfg_known)
        begin
            col_pos_next  = '0;
            row_pos_next  = '0;
            chan_pos_next = '0;
            wr_base_next  = '0;
        end
        else if (accept)
        begin
            col_pos_next = col_pos_reg + CW'(1);
            if (col_end)
            begin
                col_pos_next = '0;
                row_pos_next = row_pos_reg + ROW_W'(1);
                wr_base_next = (wr_base_reg == LAST_BASE) ? '0 : wr_base_reg + ROW_STEP;
                if (row_end)
                begin
                    row_pos_next  = '0;
                    wr_base_next  = '0;
                    chan_pos_next = chan_end ? '0 : chan_pos_reg + CHAN_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg  <= '0;
            row_pos_reg  <= '0;
            chan_pos_reg <= '0;
            wr_base_reg  <= '0;
        end
        else
        begin
            col_pos_reg  <= col_pos_next;
            row_pos_reg  <= row_pos_next;
            chan_pos_reg <= chan_pos_next;
            wr_base_reg  <= wr_base_next;
        end
    end

    // ---------------------------------------------------------------
    // Window trackers, rows per channel and columns per row
    assign row_clear = (cfg_write && cfg_known) || (accept && col_end && row_end);
    assign row_adv   = accept && col_end && row_status.hit;
    assign col_clear = (cfg_write && cfg_known) || (accept && col_end);
    assign col_adv   = accept && col_status.hit;
    assign win_hit   = row_status.hit && col_status.hit;

    mp2d_win_track #(
        .POS_W (ROW_W),
        .WIN_W (WIN_W)
    ) u_row_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (row_clear),
        .advance   (row_adv),
        .n_dim     (h_eff),
        .win       (k_eff),
        .step      (s_eff),
        .pos       (row_pos_reg),
        .status    (row_status),
        .idx       (row_idx),
        .first_pos (row_first)
    );

    mp2d_win_track #(
        .POS_W (CW),
        .WIN_W (WIN_W)
    ) u_col_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (col_clear),
        .advance   (col_adv),
        .n_dim     (w_eff),
        .win       (k_eff),
        .step      (s_eff),
        .pos       (col_pos_reg),
        .status    (col_status),
        .idx       (col_idx),
        .first_pos (col_first)
    );

    // ---------------------------------------------------------------
    // Line store: sample written on accept, window read back one entry a cycle
    assign wr_addr = wr_base_reg + ADDR_W'(col_pos_reg);
    assign rd_addr = scan_base_reg + ADDR_W'(scan_col_reg);

    mp2d_line_store #(
        .DEPTH  (STORE_DEPTH),
        .DATA_W (SAMPLE_BITS)
    ) u_store (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (wr_addr),
        .wr_data (sample),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // ---------------------------------------------------------------
    // Sequencer: next state
    assign scan_done = (scan_col_reg == scan_last_reg) && (rows_left_reg == '0);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mp2d_pkg::ST_IDLE:
                if (accept && win_hit)
                    state_next = mp2d_pkg::ST_SCAN;
            mp2d_pkg::ST_SCAN:
                if (scan_done)
                    state_next = mp2d_pkg::ST_LAST;
            mp2d_pkg::ST_LAST:
                state_next = mp2d_pkg::ST_EMIT;
            mp2d_pkg::ST_EMIT:
                if (out_load)
                    state_next = mp2d_pkg::ST_IDLE;
            default:
                state_next = mp2d_pkg::ST_IDLE;
        endcase
    end

    // Sequencer: outputs
    always_comb
    begin
        in_stall  = 1'b1;
        cfg_ready = 1'b0;
        rd_en     = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            mp2d_pkg::ST_IDLE:
            begin
                in_stall  = 1'b0;
                cfg_ready = 1'b1;
            end
            mp2d_pkg::ST_SCAN:
                rd_en = 1'b1;
            mp2d_pkg::ST_LAST:
                ;
            mp2d_pkg::ST_EMIT:
                out_load = !out_valid_reg || !out_stall;
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= mp2d_pkg::ST_IDLE;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= rd_en;
        end
    end

    // ---------------------------------------------------------------
    // Scan walk: columns of a row, then back one row in the ring
    always_comb
    begin
        scan_base_next  = scan_base_reg;
        scan_col_next   = scan_col_reg;
        scan_first_next = scan_first_reg;
        scan_last_next  = scan_last_reg;
        rows_left_next  = rows_left_reg;
        if (accept && win_hit)
        begin
            scan_base_next  = wr_base_reg;
            scan_col_next   = col_first;
            scan_first_next = col_first;
            scan_last_next  = col_pos_reg;
            rows_left_next  = WIN_W'(row_pos_reg - row_first);
        end
        else if (rd_en && !scan_done)
        begin
            if (scan_col_reg == scan_last_reg)
            begin
                scan_col_next  = scan_first_reg;
                rows_left_next = rows_left_reg - WIN_W'(1);
                scan_base_next = (scan_base_reg == '0) ? LAST_BASE : scan_base_reg - ROW_STEP;
            end
            else
            begin
                scan_col_next = scan_col_reg + CW'(1);
            end
        end
    end

    // Running maximum over returned read data
    always_comb
    begin
        best_next = best_reg;
        if (accept && win_hit)
            best_next = MIN_VALUE;
        else if (rd_pend_reg && (rd_data > best_reg))
            best_next = rd_data;
    end

    always_ff @(posedge clk)
    begin
        scan_base_reg  <= scan_base_next;
        scan_col_reg   <= scan_col_next;
        scan_first_reg <= scan_first_next;
        scan_last_reg  <= scan_last_next;
        rows_left_reg  <= rows_left_next;
        best_reg       <= best_next;
        if (accept && win_hit)
        begin
            meta_chan_reg <= chan_pos_reg;
            meta_row_reg  <= mp2d_pkg::OUT_POS_W'(row_idx);
            meta_col_reg  <= mp2d_pkg::OUT_POS_W'(col_idx);
            meta_done_reg <= chan_end && row_status.last && col_status.last;
        end
    end

    // ---------------------------------------------------------------
    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            pooled_reg   <= best_reg;
            chan_out_reg <= meta_chan_reg;
            row_out_reg  <= meta_row_reg;
            col_out_reg  <= meta_col_reg;
            done_out_reg <= meta_done_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pooled_value  = pooled_reg;
    assign channel_index = chan_out_reg;
    assign out_row       = row_out_reg;
    assign out_col       = col_out_reg;
    assign layer_done    = done_out_reg;

    // ---------------------------------------------------------------
    // Assertions
    `ASSERT_NEXT(a_hit_starts_scan, clk, rst_n, accept && win_hit, state_reg == mp2d_pkg::ST_SCAN, "window hit did not start a scan")
    `ASSERT_NEXT(a_out_held, clk, rst_n, (state_reg == mp2d_pkg::ST_EMIT) && out_valid_reg && out_stall, (state_reg == mp2d_pkg::ST_EMIT) && out_valid_reg, "pending result overwritten")
    `ASSERT_IMP(a_scan_col_range, clk, rst_n, state_reg == mp2d_pkg::ST_SCAN, (scan_col_reg <= scan_last_reg) && (rows_left_reg < k_eff), "scan walked outside the window")
    `ASSERT_IMP(a_pos_range, clk, rst_n, state_reg == mp2d_pkg::ST_IDLE, (WDIM_W'(col_pos_reg) < w_eff) && ({1'b0, row_pos_reg} < h_eff), "raster position outside the map")

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the 2-D max pooling core: directed cases and random layers.
module tb;

    localparam int SB            = mp2d_pkg::DEF_SAMPLE_BITS;
    localparam int ROW_SLOTS     = mp2d_pkg::DEF_MAX_WINDOW;
    localparam int ROW_LEN       = mp2d_pkg::DEF_MAX_WIDTH;
    localparam int STEP_CAP      = 15;
    localparam int IDLE_PCT      = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 80;
    localparam int RANDOM_BEATS  = 300;
    // worst case is a beat that closes an 8x8 window, plus stalls
    localparam int CYCLE_LIMIT   = 1000000;
    localparam logic [mp2d_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    typedef struct packed {
        logic signed [SB-1:0]                value;
        logic [mp2d_pkg::CHAN_W-1:0]         chan;
        logic [mp2d_pkg::OUT_POS_W-1:0]      row;
        logic [mp2d_pkg::OUT_POS_W-1:0]      col;
        logic                                done;
    } pool_result_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [mp2d_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
    logic [mp2d_pkg::CFG_DATA_W-1:0]   cfg_data = '0;
    logic                              in_valid = 1'b0;
    logic                              in_stall;
    logic signed [SB-1:0]              sample = '0;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    logic signed [SB-1:0]              pooled_value;
    logic [mp2d_pkg::CHAN_W-1:0]       channel_index;
    logic [mp2d_pkg::OUT_POS_W-1:0]    out_row;
    logic [mp2d_pkg::OUT_POS_W-1:0]    out_col;
    logic                              layer_done;

    // expected pooled results, oldest first
    pool_result_t pending_pools[$];
    int           mismatches = 0;
    int unsigned  idle_pct = IDLE_PCT;
    int unsigned  hold_requests = 0;
    int unsigned  samples_sent = 0;

    // predictor copy of registers, positions and line store
    logic [mp2d_pkg::HEIGHT_W-1:0]   cur_height;
    logic [mp2d_pkg::WIDTH_W-1:0]    cur_width;
    logic [mp2d_pkg::WINDOW_W-1:0]   cur_window;
    logic [mp2d_pkg::STEP_W-1:0]     cur_step;
    logic [mp2d_pkg::CHANNELS_W-1:0] cur_channels;
    int unsigned                     at_row;
    int unsigned                     at_col;
    int unsigned                     at_chan;
    logic signed [SB-1:0]            line_rows [ROW_SLOTS*ROW_LEN];

    max_pooling_2d_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample        (sample),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pooled_value  (pooled_value),
        .channel_index (channel_index),
        .out_row       (out_row),
        .out_col       (out_col),
        .layer_done    (layer_done)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // zero acts as one, oversized values saturate
    function automatic int unsigned clamp_reg(int unsigned v, int unsigned hi);
        if (v == 0)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // ceil-mode window count, dropping a last window that would start off the map
    function automatic int unsigned windows_along(int unsigned n, int unsigned k,
                                                  int unsigned s);
        int unsigned cnt;
        if (k >= n)
            return 1;
        cnt = (n - k) / s + 1 + (((n - k) % s) != 0 ? 1 : 0);
        if ((cnt - 1) * s >= n)
            cnt--;
        return cnt;
    endfunction

    // window whose clipped last position is pos, or -1
    function automatic int window_closed_at(int unsigned pos, int unsigned cnt,
                                            int unsigned n, int unsigned k,
                                            int unsigned s);
        int unsigned i;
        int unsigned last_pos;
        for (i = 0; i < cnt; i++)
        begin
            last_pos = i * s + k - 1;
            if (last_pos > n - 1)
                last_pos = n - 1;
            if (last_pos == pos)
                return int'(i);
        end
        return -1;
    endfunction

    function automatic logic signed [SB-1:0] edge_sample(int unsigned i);
        case (i % 8)
            0: return {1'b1, {(SB-1){1'b0}}};
            1: return {1'b0, {(SB-1){1'b1}}};
            2: return '0;
            3: return '1;
            4: return {{(SB-1){1'b0}}, 1'b1};
            5: return {(SB/2){2'b01}};
            6: return {(SB/2){2'b10}};
            default: return SB'($urandom());
        endcase
    endfunction

    function automatic logic signed [SB-1:0] draw_sample();
        logic signed [SB-1:0] near_zero;
        case ($urandom_range(9, 0))
            0: return {1'b1, {(SB-1){1'b0}}};
            1: return {1'b0, {(SB-1){1'b1}}};
            2:
            begin
                near_zero = SB'($urandom_range(255, 0));
                return near_zero - SB'(128);
            end
            default: return SB'($urandom());
        endcase
    endfunction

    task automatic apply_reg(input logic [mp2d_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mp2d_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            mp2d_pkg::CFG_MAP_HEIGHT:    cur_height   = data[mp2d_pkg::HEIGHT_W-1:0];
            mp2d_pkg::CFG_MAP_WIDTH:     cur_width    = data[mp2d_pkg::WIDTH_W-1:0];
            mp2d_pkg::CFG_WINDOW_SIZE:   cur_window   = data[mp2d_pkg::WINDOW_W-1:0];
            mp2d_pkg::CFG_STEP_SIZE:     cur_step     = data[mp2d_pkg::STEP_W-1:0];
            mp2d_pkg::CFG_CHANNEL_COUNT: cur_channels = data[mp2d_pkg::CHANNELS_W-1:0];
            default: return;
        endcase
        // any real register write restarts the layer
        at_row  = 0;
        at_col  = 0;
        at_chan = 0;
    endtask

    // store one beat and queue the window maximum if it closes a window
    task automatic pool_sample(input logic signed [SB-1:0] v);
        int unsigned h, w, k, s, c, nh, nw, rs, cs, r, q;
        int orow, ocol;
        logic signed [SB-1:0] best;
        pool_result_t res;
        h  = clamp_reg(32'(cur_height), mp2d_pkg::MAX_HEIGHT);
        w  = clamp_reg(32'(cur_width), mp2d_pkg::DEF_MAX_WIDTH);
        k  = clamp_reg(32'(cur_window), mp2d_pkg::DEF_MAX_WINDOW);
        s  = clamp_reg(32'(cur_step), STEP_CAP);
        c  = clamp_reg(32'(cur_channels), mp2d_pkg::MAX_CHANNELS);
        nh = windows_along(h, k, s);
        nw = windows_along(w, k, s);
        if (at_row >= h || at_col >= w || at_chan >= c)
        begin
            at_row  = 0;
            at_col  = 0;
            at_chan = 0;
        end
        line_rows[(at_row % ROW_SLOTS) * ROW_LEN + at_col] = v;
        orow = window_closed_at(at_row, nh, h, k, s);
        ocol = window_closed_at(at_col, nw, w, k, s);
        if (orow >= 0 && ocol >= 0)
        begin
            rs   = orow * s;
            cs   = ocol * s;
            best = line_rows[(rs % ROW_SLOTS) * ROW_LEN + cs];
            for (r = rs; r <= at_row; r++)
                for (q = cs; q <= at_col; q++)
                    if (line_rows[(r % ROW_SLOTS) * ROW_LEN + q] > best)
                        best = line_rows[(r % ROW_SLOTS) * ROW_LEN + q];
            res.value = best;
            res.chan  = at_chan[mp2d_pkg::CHAN_W-1:0];
            res.row   = orow[mp2d_pkg::OUT_POS_W-1:0];
            res.col   = ocol[mp2d_pkg::OUT_POS_W-1:0];
            res.done  = (at_chan == c - 1) && (orow == nh - 1) && (ocol == nw - 1);
            pending_pools.push_back(res);
        end
        // raster advance, wrapping at the end of the layer
        at_col++;
        if (at_col >= w)
        begin
            at_col = 0;
            at_row++;
            if (at_row >= h)
            begin
                at_row = 0;
                at_chan++;
                if (at_chan >= c)
                    at_chan = 0;
            end
        end
    endtask

    // offer one beat, with an occasional gap in front of it
    task automatic send_sample(input logic signed [SB-1:0] v);
        while ($urandom_range(99, 0) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= v;
        do
            @(posedge clk);
        while (in_stall);
        pool_sample(v);
        samples_sent++;
    endtask

    // block idle: every expected result seen, last beat worked off
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_pools.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // leaves cfg_valid high; the caller drops it after the last write
    task automatic write_reg(input logic [mp2d_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mp2d_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_reg(idx, data);
    endtask

    task automatic set_layer(input logic [mp2d_pkg::CFG_DATA_W-1:0] h,
                             input logic [mp2d_pkg::CFG_DATA_W-1:0] w,
                             input logic [mp2d_pkg::CFG_DATA_W-1:0] k,
                             input logic [mp2d_pkg::CFG_DATA_W-1:0] s,
                             input logic [mp2d_pkg::CFG_DATA_W-1:0] c);
        settle();
        write_reg(mp2d_pkg::CFG_MAP_HEIGHT, h);
        write_reg(mp2d_pkg::CFG_MAP_WIDTH, w);
        write_reg(mp2d_pkg::CFG_WINDOW_SIZE, k);
        write_reg(mp2d_pkg::CFG_STEP_SIZE, s);
        write_reg(mp2d_pkg::CFG_CHANNEL_COUNT, c);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_edges(input int unsigned count);
        int unsigned i;
        for (i = 0; i < count; i++)
            send_sample(edge_sample(i));
    endtask

    // 8x8 map, 2x2 window, stride 2 straight out of reset
    task automatic test_reset_defaults();
        send_edges(10);
    endtask

    // all registers zero: 1x1 map, every beat is its own window and ends the layer
    task automatic test_zero_registers();
        set_layer(0, 0, 0, 0, 0);
        send_edges(2);
    endtask

    // oversized window code saturates and covers the whole map
    task automatic test_window_over_map();
        set_layer(2, 3, 11, 1, 1);
        send_edges(6);
    endtask

    // stride 3 over a 2-wide window: column 2 never pooled, last window clipped
    task automatic test_step_over_window();
        set_layer(2, 4, 2, 3, 1);
        send_edges(8);
    endtask

    // write to an index past the register list must not restart the layer
    task automatic test_unused_index();
        set_layer(2, 4, 2, 2, 1);
        send_edges(3);
        settle();
        write_reg(CFG_UNUSED, mp2d_pkg::CFG_DATA_W'($urandom_range(2047, 0)));
        cfg_valid <= 1'b0;
        send_edges(5);
    endtask

    // saturated width and height, unit window: a result per beat across a full row
    task automatic test_widest_row();
        int unsigned i;
        set_layer(11'h7FF, 11'h7FF, 0, 0, 1);
        for (i = 0; i < ROW_LEN + 8; i++)
            send_sample(draw_sample());
    endtask

    // single column of maximum height
    task automatic test_tallest_column();
        int unsigned i;
        set_layer(mp2d_pkg::CFG_DATA_W'(mp2d_pkg::MAX_HEIGHT), 1, 1, 1, 1);
        for (i = 0; i < mp2d_pkg::MAX_HEIGHT; i++)
            send_sample(draw_sample());
    endtask

    // 1x1 maps, saturated channel count and step, run without gaps, then wrap
    task automatic test_channel_limit();
        int unsigned i;
        idle_pct = 0;
        set_layer(1, 1, 11'h7FF, 11'h7FF, 11'h7FF);
        for (i = 0; i < mp2d_pkg::MAX_CHANNELS + 2; i++)
            send_sample(draw_sample());
        idle_pct = IDLE_PCT;
    endtask

    // full 8x8 window sliding by one
    task automatic test_largest_window();
        int unsigned i;
        set_layer(9, 9, mp2d_pkg::CFG_DATA_W'(mp2d_pkg::DEF_MAX_WINDOW), 1, 1);
        for (i = 0; i < 81; i++)
            send_sample(draw_sample());
    endtask

    // receiver holds off while beats keep coming, so the core backs up
    task automatic test_output_backpressure();
        int unsigned i;
        set_layer(4, 4, 1, 1, 2);
        hold_requests++;
        for (i = 0; i < 32; i++)
            send_sample(draw_sample());
    endtask

    // random layer shapes, mostly small and run through whole layers
    task automatic test_random_layers();
        int unsigned target, layer_len, burst, i;
        logic [mp2d_pkg::CFG_DATA_W-1:0] h, w, k, s, c;
        target = samples_sent + RANDOM_BEATS;
        while (samples_sent < target)
        begin
            if ($urandom_range(9, 0) == 0)
            begin
                h = mp2d_pkg::CFG_DATA_W'($urandom_range(2047, 0));
                w = mp2d_pkg::CFG_DATA_W'($urandom_range(2047, 0));
                k = mp2d_pkg::CFG_DATA_W'($urandom_range(15, 0));
                s = mp2d_pkg::CFG_DATA_W'($urandom_range(15, 0));
                c = mp2d_pkg::CFG_DATA_W'($urandom_range(2047, 0));
            end
            else
            begin
                h = mp2d_pkg::CFG_DATA_W'($urandom_range(12, 1));
                w = mp2d_pkg::CFG_DATA_W'($urandom_range(12, 1));
                k = mp2d_pkg::CFG_DATA_W'(($urandom_range(3, 0) == 0) ?
                        $urandom_range(9, 0) : $urandom_range(4, 1));
                s = mp2d_pkg::CFG_DATA_W'(($urandom_range(4, 0) == 0) ?
                        $urandom_range(15, 0) : $urandom_range(4, 1));
                c = mp2d_pkg::CFG_DATA_W'($urandom_range(3, 1));
            end
            set_layer(h, w, k, s, c);
            layer_len = clamp_reg(32'(cur_height), mp2d_pkg::MAX_HEIGHT)
                        * clamp_reg(32'(cur_width), mp2d_pkg::DEF_MAX_WIDTH)
                        * clamp_reg(32'(cur_channels), mp2d_pkg::MAX_CHANNELS);
            if (layer_len > 300)
                burst = $urandom_range(300, 20);
            else
                burst = layer_len * $urandom_range(2, 1) + $urandom_range(layer_len, 0);
            for (i = 0; i < burst; i++)
                send_sample(draw_sample());
        end
    endtask

    // receiver: random stalls, plus a long hold when one is requested
    initial
    begin : receiver
        int unsigned hold_left;
        int unsigned holds_seen;
        hold_left  = 0;
        holds_seen = 0;
        forever
        begin
            @(posedge clk);
            if (holds_seen != hold_requests)
            begin
                holds_seen = hold_requests;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99, 0) < idle_pct);
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin : check_results
        pool_result_t want;
        pool_result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {pooled_value, channel_index, out_row, out_col, layer_done};
            if (pending_pools.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: value %0d chan %0d row %0d col %0d done %0b",
                             got.value, got.chan, got.row, got.col, got.done);
            end
            else
            begin
                want = pending_pools.pop_front();
                if (got.value !== want.value || got.chan !== want.chan ||
                    got.row !== want.row || got.col !== want.col || got.done !== want.done)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp value %0d chan %0d row %0d col %0d done %0b, %s",
                                 want.value, want.chan, want.row, want.col, want.done,
                                 $sformatf("got value %0d chan %0d row %0d col %0d done %0b",
                                           got.value, got.chan, got.row, got.col, got.done));
                end
            end
        end
    end

    // cycle limit
    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles <= CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("max_pooling_2d_core test failed");
        $finish;
    end

    initial
    begin : run
        cur_height   = mp2d_pkg::RST_MAP_HEIGHT;
        cur_width    = mp2d_pkg::RST_MAP_WIDTH;
        cur_window   = mp2d_pkg::RST_WINDOW_SIZE;
        cur_step     = mp2d_pkg::RST_STEP_SIZE;
        cur_channels = mp2d_pkg::RST_CHANNEL_COUNT;
        at_row       = 0;
        at_col       = 0;
        at_chan      = 0;
        foreach (line_rows[i])
            line_rows[i] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_zero_registers();
        test_window_over_map();
        test_step_over_window();
        test_unused_index();
        test_widest_row();
        test_tallest_column();
        test_channel_limit();
        test_largest_window();
        test_output_backpressure();
        test_random_layers();

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_pools.size() == 0)
            $display("max_pooling_2d_core test passed");
        else
        begin
            if (pending_pools.size() != 0)
                $display("%0d expected results never arrived", pending_pools.size());
            $display("max_pooling_2d_core test failed");
        end
        $finish;
    end

endmodule
